>>> rtl/drsc_pkg.sv
// Types and constants shared by the DNS response statistics counter bank.
package drsc_pkg;

  localparam int NUM_COUNTERS = 66;
  localparam int IDX_W = 7;
  localparam int OFF_W = 5;
  localparam int BLOCK_BASE = 2;
  localparam int VALUE_W = 64;
  localparam int LEN_W = 16;
  localparam int NUM_EDNS_LIMITS = 9;

  typedef enum logic [1:0] {
    OP_PACKET = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STATUS_HANDLED = 2'd0,
    STATUS_SKIPPED = 2'd1,
    STATUS_REPLY   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    IP_V4      = 2'd0,
    IP_V6      = 2'd1,
    IP_UNKNOWN = 2'd2
  } ip_type_t;

  // Bit positions within the flags field.
  localparam int F_RESPONSE = 0;
  localparam int F_VALID    = 1;
  localparam int F_FRAG     = 2;
  localparam int F_REASM    = 3;
  localparam int F_TCP      = 4;
  localparam int F_EDNS     = 5;
  localparam int F_DO       = 6;
  localparam int F_ECS      = 7;
  localparam int F_EXPOPT   = 8;
  localparam int F_TC       = 9;

  // Counter offsets within one IP version block.
  localparam logic [OFF_W-1:0] O_FRAG    = 5'd0;
  localparam logic [OFF_W-1:0] O_UNFRAG  = 5'd1;
  localparam logic [OFF_W-1:0] O_UDP     = 5'd2;
  localparam logic [OFF_W-1:0] O_TCP     = 5'd3;
  localparam logic [OFF_W-1:0] O_NOEDNS  = 5'd4;
  localparam logic [OFF_W-1:0] O_EBUF    = 5'd5;
  localparam logic [OFF_W-1:0] O_DOSET   = 5'd15;
  localparam logic [OFF_W-1:0] O_DOUNSET = 5'd16;
  localparam logic [OFF_W-1:0] O_ECS     = 5'd17;
  localparam logic [OFF_W-1:0] O_NOECS   = 5'd18;
  localparam logic [OFF_W-1:0] O_EXPOPT  = 5'd19;
  localparam logic [OFF_W-1:0] O_RSIZE   = 5'd20;
  localparam logic [OFF_W-1:0] O_BYTES   = 5'd29;
  localparam logic [OFF_W-1:0] O_COUNTED = 5'd30;
  localparam logic [OFF_W-1:0] O_TCSET   = 5'd31;

  localparam logic [LEN_W-1:0] EDNS_LIMITS [NUM_EDNS_LIMITS] = '{
    16'd512, 16'd1000, 16'd1500, 16'd2000, 16'd2500,
    16'd3000, 16'd3500, 16'd4000, 16'd4500
  };

  localparam logic [LEN_W-1:0] SIZE_TOP_LIMIT = 16'd4096;

  // Index of a counter within the block of the given IP version.
  function automatic logic [IDX_W-1:0] blk_idx(input logic ver,
                                               input logic [OFF_W-1:0] off);
    return IDX_W'(BLOCK_BASE) + {ver, off};
  endfunction

endpackage

>>> rtl/dns_response_stats_counters_unit.sv
// Top level of the DNS response statistics counter bank.
// Throughput: one item per cycle unless the output stalls; the input
// register feeds the decode and counter update logic, which writes the
// output register in the same cycle.
// Reset clears all 66 counters and the valid flags of both registers.
// Output stalls hold the input register and freeze every counter.
module dns_response_stats_counters_unit #(
  parameter int COUNTER_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [1:0]  in_ip_type,
  input  logic [9:0]  in_flags,
  input  logic [15:0] in_edns_buffer_size,
  input  logic [15:0] in_response_length,
  input  logic [6:0]  in_counter_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [63:0] out_counter_value
);
  import drsc_pkg::*;

  typedef logic [COUNTER_WIDTH-1:0] cnt_t;

  logic                   s1_valid_r;
  logic [1:0]             s1_op_r;
  logic [1:0]             s1_ip_type_r;
  logic [9:0]             s1_flags_r;
  logic [LEN_W-1:0]       s1_ebuf_r;
  logic [LEN_W-1:0]       s1_rlen_r;
  logic [IDX_W-1:0]       s1_idx_r;

  logic                   out_valid_r;
  status_t                out_status_r;
  logic [VALUE_W-1:0]     out_value_r;

  cnt_t                   bank_r [NUM_COUNTERS];
  cnt_t                   bank_nxt [NUM_COUNTERS];

  logic                   adv;
  logic [NUM_COUNTERS-1:0] hit;
  logic                   clr;
  status_t                status_nxt;
  logic [VALUE_W-1:0]     value_nxt;
  logic                   ver;
  logic [NUM_EDNS_LIMITS-1:0] ebuf_ge;
  logic [3:0]             ebuf_bkt;
  logic [3:0]             rsize_bkt;

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;
  assign ver      = s1_ip_type_r[0];

  always_comb begin
    for (int i = 0; i < NUM_EDNS_LIMITS; i++) begin
      ebuf_ge[i] = (s1_ebuf_r >= EDNS_LIMITS[i]);
    end
    ebuf_bkt = 4'($countones(ebuf_ge));
    if (s1_rlen_r >= SIZE_TOP_LIMIT) begin
      rsize_bkt = 4'd8;
    end else begin
      rsize_bkt = {1'b0, s1_rlen_r[11:9]};
    end
  end

  always_comb begin
    hit        = '0;
    clr        = 1'b0;
    status_nxt = STATUS_REPLY;
    value_nxt  = '0;
    case (s1_op_r)
      OP_PACKET: begin
        status_nxt = STATUS_SKIPPED;
        if (s1_flags_r[F_RESPONSE] && !s1_ip_type_r[1]) begin
          hit[ver] = 1'b1;
          if (s1_flags_r[F_VALID]) begin
            status_nxt = STATUS_HANDLED;
            if (s1_flags_r[F_FRAG] || s1_flags_r[F_REASM]) begin
              hit[blk_idx(ver, O_FRAG)] = 1'b1;
            end else begin
              hit[blk_idx(ver, O_UNFRAG)] = 1'b1;
            end
            if (s1_flags_r[F_TCP]) begin
              hit[blk_idx(ver, O_TCP)] = 1'b1;
            end else begin
              hit[blk_idx(ver, O_UDP)] = 1'b1;
            end
            if (s1_flags_r[F_EDNS]) begin
              if (s1_flags_r[F_DO]) begin
                hit[blk_idx(ver, O_DOSET)] = 1'b1;
              end else begin
                hit[blk_idx(ver, O_DOUNSET)] = 1'b1;
              end
              hit[blk_idx(ver, O_EBUF + OFF_W'(ebuf_bkt))] = 1'b1;
              if (s1_flags_r[F_ECS]) begin
                hit[blk_idx(ver, O_ECS)] = 1'b1;
              end else begin
                hit[blk_idx(ver, O_NOECS)] = 1'b1;
              end
              if (s1_flags_r[F_EXPOPT]) begin
                hit[blk_idx(ver, O_EXPOPT)] = 1'b1;
              end
            end else begin
              hit[blk_idx(ver, O_NOEDNS)] = 1'b1;
            end
            if (s1_rlen_r != '0) begin
              hit[blk_idx(ver, O_RSIZE + OFF_W'(rsize_bkt))] = 1'b1;
              hit[blk_idx(ver, O_BYTES)]                     = 1'b1;
              hit[blk_idx(ver, O_COUNTED)]                   = 1'b1;
            end
            if (s1_flags_r[F_TC]) begin
              hit[blk_idx(ver, O_TCSET)] = 1'b1;
            end
          end
        end
      end
      OP_READ: begin
        if (s1_idx_r < IDX_W'(NUM_COUNTERS)) begin
          value_nxt = VALUE_W'(bank_r[s1_idx_r]);
        end
      end
      OP_CLEAR: begin
        clr = 1'b1;
      end
      default: begin
        status_nxt = STATUS_REPLY;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < NUM_COUNTERS; i++) begin
      if (clr) begin
        bank_nxt[i] = '0;
      end else if (!hit[i]) begin
        bank_nxt[i] = bank_r[i];
      end else if (IDX_W'(i) == blk_idx(1'b0, O_BYTES) ||
                   IDX_W'(i) == blk_idx(1'b1, O_BYTES)) begin
        bank_nxt[i] = bank_r[i] + COUNTER_WIDTH'(s1_rlen_r);
      end else begin
        bank_nxt[i] = bank_r[i] + cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        bank_r[i] <= '0;
      end
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        for (int i = 0; i < NUM_COUNTERS; i++) begin
          bank_r[i] <= bank_nxt[i];
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r      <= in_op;
      s1_ip_type_r <= in_ip_type;
      s1_flags_r   <= in_flags;
      s1_ebuf_r    <= in_edns_buffer_size;
      s1_rlen_r    <= in_response_length;
      s1_idx_r     <= in_counter_index;
    end
    if (adv) begin
      out_status_r <= status_nxt;
      out_value_r  <= value_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_counter_value = out_value_r;

  a_hold_bank: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(bank_r[0]) && $stable(bank_r[NUM_COUNTERS-1]))
    else $error("counter changed without an item being processed");

  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_op_r == OP_CLEAR |=> bank_r[0] == '0 && bank_r[NUM_COUNTERS-1] == '0)
    else $error("clear did not zero the counter bank");

  a_query_skip: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_op_r == OP_PACKET && !s1_flags_r[F_RESPONSE]
    |=> out_status_r == STATUS_SKIPPED)
    else $error("query was not reported as skipped");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != STATUS_REPLY |-> out_value_r == '0)
    else $error("packet result carries a nonzero counter value");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stalled with an empty input register");

endmodule

>>> tb/tb_dns_response_stats_counters_unit.sv
// Self-checking testbench for the DNS response statistics counter bank.
module tb_dns_response_stats_counters_unit;
  import drsc_pkg::*;

  localparam int PERIOD = 8;
  localparam int RANDOM_ITEMS = 1000;
  localparam int QUIET_TAIL = 150;
  localparam int LONG_HOLD = 64;
  localparam int HOLD_AFTER = 300;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int BLOCK_LEN = 1 << OFF_W;
  localparam int SIZE_STEP_LOG2 = 9;
  localparam int V6_BASE = BLOCK_BASE + BLOCK_LEN;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] IP_RESERVED = 2'd3;

  localparam logic [9:0] FL_RSP = 10'(1 << F_RESPONSE);
  localparam logic [9:0] FL_VLD = 10'(1 << F_VALID);
  localparam logic [9:0] FL_FRG = 10'(1 << F_FRAG);
  localparam logic [9:0] FL_RSM = 10'(1 << F_REASM);
  localparam logic [9:0] FL_TCP = 10'(1 << F_TCP);
  localparam logic [9:0] FL_EDN = 10'(1 << F_EDNS);
  localparam logic [9:0] FL_DOB = 10'(1 << F_DO);
  localparam logic [9:0] FL_ECS = 10'(1 << F_ECS);
  localparam logic [9:0] FL_EXP = 10'(1 << F_EXPOPT);
  localparam logic [9:0] FL_TCB = 10'(1 << F_TC);
  localparam logic [9:0] FL_ALL = 10'h3FF;

  typedef struct {
    status_t     st;
    logic [63:0] val;
  } reply_t;

  typedef struct {
    logic [1:0]       op;
    logic [1:0]       ipt;
    logic [9:0]       fl;
    logic [15:0]      eb;
    logic [15:0]      rl;
    logic [IDX_W-1:0] ix;
    bit               typed;
    reply_t           want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_op;
  logic [1:0]  in_ip_type;
  logic [9:0]  in_flags;
  logic [15:0] in_edns_buffer_size;
  logic [15:0] in_response_length;
  logic [6:0]  in_counter_index;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [63:0] out_counter_value;

  logic [63:0] stats_bank [NUM_COUNTERS];
  reply_t      expected_replies [$];
  stim_row_t   directed_rows [$];
  stim_row_t   offered_row;
  reply_t      predicted;
  reply_t      oldest;
  bit          gaps_on;
  bit          long_hold_done;
  bit          moved;
  int          accepted_items;
  int          stalled_cycles;
  int          mismatches;
  int          n_handled;
  int          n_skipped;
  int          n_replies;

  dns_response_stats_counters_unit uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_op               (in_op),
    .in_ip_type          (in_ip_type),
    .in_flags            (in_flags),
    .in_edns_buffer_size (in_edns_buffer_size),
    .in_response_length  (in_response_length),
    .in_counter_index    (in_counter_index),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_counter_value   (out_counter_value)
  );

  always #(PERIOD / 2) clk = ~clk;

  task automatic bump_counter(input int idx, input logic [63:0] amount);
    stats_bank[idx] = stats_bank[idx] + amount;
  endtask

  task automatic predict_reply(input logic [1:0] op, input logic [1:0] ipt,
                               input logic [9:0] fl, input logic [15:0] eb,
                               input logic [15:0] rl, input logic [IDX_W-1:0] ix,
                               output reply_t r);
    int base;
    int eb_bin;
    int rl_bin;
    r.st = STATUS_REPLY;
    r.val = '0;
    case (op)
      OP_PACKET: begin
        r.st = STATUS_SKIPPED;
        if (fl[F_RESPONSE] && ipt <= IP_V6) begin
          bump_counter(int'(ipt), 64'd1);
          if (fl[F_VALID]) begin
            r.st = STATUS_HANDLED;
            base = BLOCK_BASE + int'(ipt) * BLOCK_LEN;
            bump_counter(base + ((fl[F_FRAG] || fl[F_REASM]) ? O_FRAG : O_UNFRAG), 64'd1);
            bump_counter(base + (fl[F_TCP] ? O_TCP : O_UDP), 64'd1);
            if (fl[F_EDNS]) begin
              eb_bin = NUM_EDNS_LIMITS;
              for (int k = NUM_EDNS_LIMITS - 1; k >= 0; k--) begin
                if (eb < EDNS_LIMITS[k]) eb_bin = k;
              end
              bump_counter(base + (fl[F_DO] ? O_DOSET : O_DOUNSET), 64'd1);
              bump_counter(base + O_EBUF + eb_bin, 64'd1);
              bump_counter(base + (fl[F_ECS] ? O_ECS : O_NOECS), 64'd1);
              if (fl[F_EXPOPT]) bump_counter(base + O_EXPOPT, 64'd1);
            end else begin
              bump_counter(base + O_NOEDNS, 64'd1);
            end
            if (rl != 0) begin
              rl_bin = (rl >= SIZE_TOP_LIMIT) ? 8 : int'(rl >> SIZE_STEP_LOG2);
              bump_counter(base + O_RSIZE + rl_bin, 64'd1);
              bump_counter(base + O_BYTES, 64'(rl));
              bump_counter(base + O_COUNTED, 64'd1);
            end
            if (fl[F_TC]) bump_counter(base + O_TCSET, 64'd1);
          end
        end
      end
      OP_READ: begin
        if (ix < NUM_COUNTERS) r.val = stats_bank[ix];
      end
      OP_CLEAR: begin
        foreach (stats_bank[k]) stats_bank[k] = '0;
      end
      default: begin
      end
    endcase
  endtask

  task automatic add_row(input logic [1:0] op, input logic [1:0] ipt,
                         input logic [9:0] fl, input logic [15:0] eb,
                         input logic [15:0] rl, input logic [IDX_W-1:0] ix,
                         input bit typed, input status_t st, input logic [63:0] v);
    stim_row_t r;
    r.op = op;
    r.ipt = ipt;
    r.fl = fl;
    r.eb = eb;
    r.rl = rl;
    r.ix = ix;
    r.typed = typed;
    r.want.st = st;
    r.want.val = v;
    directed_rows.push_back(r);
  endtask

  function automatic logic [15:0] pick_len();
    case ($urandom_range(0, 3))
      0: return EDNS_LIMITS[$urandom_range(0, NUM_EDNS_LIMITS - 1)] - 16'($urandom_range(0, 1));
      1: return 16'($urandom_range(1, 8) << SIZE_STEP_LOG2) - 16'($urandom_range(0, 1));
      2: return 16'($urandom_range(0, 5000));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic make_random_item(output stim_row_t r);
    int sel;
    sel = $urandom_range(0, 99);
    r.op = 2'($urandom);
    r.ipt = 2'($urandom);
    r.fl = 10'($urandom);
    r.eb = 16'($urandom);
    r.rl = 16'($urandom);
    r.ix = IDX_W'($urandom);
    r.typed = 1'b0;
    r.want.st = STATUS_REPLY;
    r.want.val = '0;
    if (sel < 60) begin
      r.op = OP_PACKET;
      if ($urandom_range(0, 9) != 0) r.ipt = 2'($urandom_range(0, 1));
      if ($urandom_range(0, 4) != 0) r.fl = r.fl | FL_RSP | FL_VLD;
      r.eb = pick_len();
      r.rl = ($urandom_range(0, 7) == 0) ? 16'd0 : pick_len();
    end else if (sel < 92) begin
      r.op = OP_READ;
      if ($urandom_range(0, 7) != 0) r.ix = IDX_W'($urandom_range(0, NUM_COUNTERS - 1));
    end else if (sel < 94) begin
      r.op = OP_CLEAR;
    end else if (sel < 97) begin
      r.op = OP_UNUSED;
    end else begin
      r.op = OP_PACKET;
    end
  endtask

  task automatic offer_item(input stim_row_t r);
    int gap;
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(negedge clk);
    end
    in_op <= r.op;
    in_ip_type <= r.ipt;
    in_flags <= r.fl;
    in_edns_buffer_size <= r.eb;
    in_response_length <= r.rl;
    in_counter_index <= r.ix;
    in_valid <= 1'b1;
    offered_row = r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Result receiver: random short stalls, plus one long hold to fill the block.
  initial begin : result_sink
    int stall_left;
    out_ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!long_hold_done && accepted_items >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        stall_left = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      moved = 1'b0;
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (expected_replies.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, status %0d value %0h", $time, out_status,
                   out_counter_value);
        end else begin
          oldest = expected_replies.pop_front();
          if (out_status !== oldest.st) begin
            mismatches++;
            $display("%0t: status mismatch, expected %0d, got %0d", $time, oldest.st,
                     out_status);
          end
          if (out_counter_value !== oldest.val) begin
            mismatches++;
            $display("%0t: counter value mismatch, expected %0h, got %0h", $time,
                     oldest.val, out_counter_value);
          end
          case (oldest.st)
            STATUS_HANDLED: n_handled++;
            STATUS_SKIPPED: n_skipped++;
            default: n_replies++;
          endcase
        end
      end
      if (in_valid && in_ready) begin
        moved = 1'b1;
        predict_reply(in_op, in_ip_type, in_flags, in_edns_buffer_size, in_response_length,
                      in_counter_index, predicted);
        expected_replies.push_back(offered_row.typed ? offered_row.want : predicted);
        accepted_items++;
      end
      if (moved || (!in_valid && expected_replies.size() == 0)) begin
        stalled_cycles = 0;
      end else begin
        stalled_cycles++;
      end
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, stalled_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    stim_row_t r;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_PACKET;
    in_ip_type = IP_V4;
    in_flags = '0;
    in_edns_buffer_size = '0;
    in_response_length = '0;
    in_counter_index = '0;
    offered_row.typed = 1'b0;
    gaps_on = 1'b1;
    long_hold_done = 1'b0;
    accepted_items = 0;
    stalled_cycles = 0;
    mismatches = 0;
    n_handled = 0;
    n_skipped = 0;
    n_replies = 0;
    foreach (stats_bank[k]) stats_bank[k] = '0;

    add_row(OP_READ, IP_V4, '0, '0, '0, '0, 1, STATUS_REPLY, 64'd0);
    add_row(OP_READ, IP_V4, '0, '0, '0, IDX_W'(NUM_COUNTERS - 1), 1, STATUS_REPLY, 64'd0);
    add_row(OP_READ, IP_V4, '0, '0, '0, '1, 1, STATUS_REPLY, 64'd0);
    add_row(OP_UNUSED, IP_RESERVED, FL_ALL, '1, '1, '1, 1, STATUS_REPLY, 64'd0);
    add_row(OP_PACKET, IP_V4, FL_ALL & ~FL_RSP, 16'd1000, 16'd100, '0, 1, STATUS_SKIPPED,
            64'd0);
    add_row(OP_PACKET, IP_UNKNOWN, FL_RSP | FL_VLD, 16'd1000, 16'd100, '0, 1, STATUS_SKIPPED,
            64'd0);
    add_row(OP_PACKET, IP_RESERVED, FL_ALL, 16'd1000, 16'd100, '0, 1, STATUS_SKIPPED, 64'd0);
    add_row(OP_PACKET, IP_V4, FL_RSP, 16'd1000, 16'd100, '0, 1, STATUS_SKIPPED, 64'd0);
    add_row(OP_READ, IP_V4, '0, '0, '0, '0, 1, STATUS_REPLY, 64'd1);
    add_row(OP_PACKET, IP_V4, FL_ALL, '0, '1, '0, 1, STATUS_HANDLED, 64'd0);
    add_row(OP_PACKET, IP_V6, FL_RSP | FL_VLD, '1, '0, '0, 1, STATUS_HANDLED, 64'd0);
    add_row(OP_PACKET, IP_V6, FL_RSP | FL_VLD | FL_EDN, 16'd511, 16'd511, '0, 0,
            STATUS_REPLY, 64'd0);
    add_row(OP_PACKET, IP_V4, FL_RSP | FL_VLD | FL_EDN | FL_DOB, 16'd512, 16'd512, '0, 0,
            STATUS_REPLY, 64'd0);
    add_row(OP_PACKET, IP_V4, FL_RSP | FL_VLD | FL_EDN | FL_ECS | FL_FRG, 16'd4499, 16'd4095,
            '0, 0, STATUS_REPLY, 64'd0);
    add_row(OP_PACKET, IP_V6, FL_RSP | FL_VLD | FL_EDN | FL_EXP | FL_RSM | FL_TCP, 16'd4500,
            16'd4096, '0, 0, STATUS_REPLY, 64'd0);
    add_row(OP_PACKET, IP_V4, FL_RSP | FL_VLD | FL_TCB, 16'd1000, 16'd1, '0, 0, STATUS_REPLY,
            64'd0);
    add_row(OP_READ, IP_V4, '0, '0, '0, IDX_W'(BLOCK_BASE + O_BYTES), 0, STATUS_REPLY, 64'd0);
    add_row(OP_READ, IP_V4, '0, '0, '0, IDX_W'(V6_BASE + O_COUNTED), 0, STATUS_REPLY, 64'd0);
    add_row(OP_READ, IP_V4, '0, '0, '0, IDX_W'(1), 0, STATUS_REPLY, 64'd0);
    add_row(OP_READ, IP_V4, '0, '0, '0, IDX_W'(BLOCK_BASE + O_EBUF), 0, STATUS_REPLY, 64'd0);
    add_row(OP_CLEAR, IP_V4, '0, '0, '0, '0, 1, STATUS_REPLY, 64'd0);
    add_row(OP_READ, IP_V4, '0, '0, '0, '0, 1, STATUS_REPLY, 64'd0);
    add_row(OP_READ, IP_V4, '0, '0, '0, IDX_W'(BLOCK_BASE + O_BYTES), 1, STATUS_REPLY, 64'd0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) offer_item(directed_rows[k]);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      gaps_on = (i < RANDOM_ITEMS - QUIET_TAIL) && ((i % 200) < 150);
      make_random_item(r);
      offer_item(r);
    end

    gaps_on = 1'b0;
    for (int k = 0; k < NUM_COUNTERS; k++) begin
      make_random_item(r);
      r.op = OP_READ;
      r.ix = IDX_W'(k);
      offer_item(r);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d transfers: %0d packets handled, %0d skipped, %0d read or clear",
             accepted_items, n_handled, n_skipped, n_replies);
    $display("replies, with random stalls on both sides, one long output hold and %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
